[rtl/core/mst_pkg.sv]
`timescale 1ns / 1ps
package mst_pkg;

  localparam int SLOT_IDX_W = 4;

  localparam logic [2:0] KIND_DOWN     = 3'd0;
  localparam logic [2:0] KIND_PTR_DOWN = 3'd1;
  localparam logic [2:0] KIND_MOVE     = 3'd2;
  localparam logic [2:0] KIND_UP       = 3'd3;
  localparam logic [2:0] KIND_PTR_UP   = 3'd4;
  localparam logic [2:0] KIND_CANCEL   = 3'd5;
  localparam logic [2:0] KIND_READ     = 3'd6;
  localparam logic [2:0] KIND_OTHER    = 3'd7;

  localparam logic [5:0] MAX_CONTACTS = 6'd32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  pointer_id;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [7:0]  pressure_in;
    logic [5:0]  pointer_count;
    logic [3:0]  query_slot;
  } in_item_t;

  typedef struct packed {
    logic        consumed;
    logic        slot_found;
    logic [3:0]  slot_index;
    logic [5:0]  active_count;
    logic        read_valid;
    logic [4:0]  read_pointer_id;
    logic [15:0] read_x;
    logic [15:0] read_y;
    logic [15:0] read_prev_x;
    logic [15:0] read_prev_y;
    logic [7:0]  read_pressure;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  pointer_id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] prev_x;
    logic [15:0] prev_y;
    logic [7:0]  pressure;
  } slot_entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_addr;
    slot_entry_t           wr_data;
    logic                  clr_en;
    logic [SLOT_IDX_W-1:0] clr_addr;
    logic                  clr_all;
  } store_cmd_t;

endpackage

[rtl/core/mst_slot_store.sv]
`timescale 1ns / 1ps
module mst_slot_store #(
  parameter int SLOT_COUNT = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mst_pkg::store_cmd_t      cmd,
  output mst_pkg::slot_entry_t     rd_data,
  output logic [SLOT_COUNT-1:0]    active
);
  import mst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  slot_entry_t mem [SLOT_COUNT];

  // active flags double as entry valid bits: a clear drops only the flag, the entry's data stays in memory
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.clr_all) begin
      active <= '0;
    end else begin
      if (cmd.wr_en) active[cmd.wr_addr[IDX_W-1:0]] <= 1'b1;
      if (cmd.clr_en) active[cmd.clr_addr[IDX_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr[IDX_W-1:0]] <= cmd.wr_data;
    if (cmd.rd_en) rd_data <= mem[cmd.rd_addr[IDX_W-1:0]];
  end

endmodule

[rtl/core/multitouch_slot_tracker_core.sv]
`timescale 1ns / 1ps
// channel   signals                     direction  payload
// in        in_valid in_ready in_data   into core  mst_pkg::in_item_t
// out       out_valid out_ready out_data out of core mst_pkg::out_item_t
//
// one item at a time; down, cancel, read and ignored kinds skip the scan
// move and up kinds scan the slot memory one entry per cycle
// the scan stops early at the first active slot with a matching id
// reset clears the active flags and the contact count
// a result waits in the output register; the next item is taken meanwhile
module multitouch_slot_tracker_core #(
  parameter int SLOT_COUNT = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mst_pkg::out_item_t out_data
);
  import mst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOT_COUNT);
  localparam logic [4:0] QS_LIMIT = 5'(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                state;
  in_item_t              item;
  logic [CNT_W-1:0]      idx;
  logic                  cmp_vld;
  logic [SLOT_IDX_W-1:0] cmp_idx;
  logic                  found;
  logic [SLOT_IDX_W-1:0] slot;
  logic [5:0]            count;
  logic [5:0]            count_next;

  store_cmd_t            cmd;
  slot_entry_t           rd_data;
  logic [SLOT_COUNT-1:0] active;

  logic                  in_acc;
  logic                  hit;
  logic                  go;
  logic                  ff_found;
  logic [SLOT_IDX_W-1:0] ff_idx;
  logic [5:0]            pc_sat;
  logic                  qs_ok;
  out_item_t             res;

  mst_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_data (rd_data),
    .active  (active)
  );

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign go       = (state == S_DONE) && (!out_valid || out_ready);
  assign hit      = (state == S_SCAN) && cmp_vld && active[cmp_idx[IDX_W-1:0]] &&
                    (rd_data.pointer_id == item.pointer_id);
  assign pc_sat   = (item.pointer_count > MAX_CONTACTS) ? MAX_CONTACTS : item.pointer_count;
  assign qs_ok    = ({1'b0, item.query_slot} < QS_LIMIT);

  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        ff_found = 1'b1;
        ff_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd        = '0;
    res        = '0;
    count_next = count;
    res.consumed = 1'b1;

    if (in_acc && in_data.kind == KIND_READ && ({1'b0, in_data.query_slot} < QS_LIMIT)) begin
      cmd.rd_en   = 1'b1;
      cmd.rd_addr = in_data.query_slot;
    end
    if (state == S_SCAN && !hit && idx < SCAN_END) begin
      cmd.rd_en   = 1'b1;
      cmd.rd_addr = SLOT_IDX_W'(idx);
    end

    unique case (item.kind) inside
      KIND_DOWN, KIND_PTR_DOWN: begin
        res.slot_found = ff_found;
        res.slot_index = ff_found ? ff_idx : '0;
        count_next     = (item.kind == KIND_DOWN) ? 6'd1 : pc_sat;
        cmd.wr_en      = go && ff_found;
        cmd.wr_addr    = ff_idx;
        cmd.wr_data    = '{pointer_id: item.pointer_id, x: item.x_pos, y: item.y_pos,
                           prev_x: 16'd0, prev_y: 16'd0, pressure: item.pressure_in};
      end
      KIND_MOVE: begin
        res.slot_found = found;
        res.slot_index = found ? slot : '0;
        count_next     = pc_sat;
        cmd.wr_en      = go && found;
        cmd.wr_addr    = slot;
        cmd.wr_data    = '{pointer_id: rd_data.pointer_id, x: item.x_pos, y: item.y_pos,
                           prev_x: rd_data.x, prev_y: rd_data.y, pressure: item.pressure_in};
      end
      KIND_UP, KIND_PTR_UP: begin
        res.slot_found = found;
        res.slot_index = found ? slot : '0;
        if (item.kind == KIND_UP) count_next = 6'd0;
        else count_next = (pc_sat == 6'd0) ? 6'd0 : pc_sat - 6'd1;
        cmd.clr_en     = go && found;
        cmd.clr_addr   = slot;
      end
      KIND_CANCEL: begin
        count_next  = 6'd0;
        cmd.clr_all = go;
      end
      KIND_READ: begin
        if (qs_ok && active[item.query_slot[IDX_W-1:0]]) begin
          res.read_valid      = 1'b1;
          res.read_pointer_id = rd_data.pointer_id;
          res.read_x          = rd_data.x;
          res.read_y          = rd_data.y;
          res.read_prev_x     = rd_data.prev_x;
          res.read_prev_y     = rd_data.prev_y;
          res.read_pressure   = rd_data.pressure;
        end
      end
      KIND_OTHER: begin
        res.consumed = 1'b0;
      end
      default: begin
        res.consumed = 1'b0;
      end
    endcase
    res.active_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= 6'd0;
      idx       <= '0;
      cmp_vld   <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            idx     <= '0;
            cmp_vld <= 1'b0;
            found   <= 1'b0;
            if (in_data.kind == KIND_MOVE || in_data.kind == KIND_UP ||
                in_data.kind == KIND_PTR_UP) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            state <= S_DONE;
          end else if (idx == SCAN_END) begin
            state <= S_DONE;
          end else begin
            cmp_vld <= 1'b1;
            idx     <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (go) begin
            count     <= count_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item <= in_data;
    if (state == S_SCAN && !hit) cmp_idx <= SLOT_IDX_W'(idx);
    if (hit) slot <= cmp_idx;
    if (go) out_data <= res;
  end

endmodule

[tb/multitouch_slot_tracker_core_test.sv]
`timescale 1ns / 1ps
module multitouch_slot_tracker_core_test;
  import mst_pkg::*;

  localparam int SLOT_N      = 10;
  localparam int RANDOM_N    = 500;
  localparam int TAIL_CYCLES = 2 * SLOT_N + 8;
  localparam int CYCLE_LIMIT = 400000;

  class contact_table;
    bit          live[SLOT_N];
    slot_entry_t tab[SLOT_N];
    logic [5:0]  contacts;
    out_item_t   due[$];
    int          errors;
    int          items_seen;
    int          results_seen;
    int          read_hits;
    int          full_downs;
    int          id_misses;

    function new();
      for (int i = 0; i < SLOT_N; i++) begin
        live[i] = 1'b0;
        tab[i] = '0;
      end
      contacts = '0;
    endfunction

    function int slot_of(logic [4:0] id);
      for (int i = 0; i < SLOT_N; i++)
        if (live[i] && tab[i].pointer_id == id)
          return i;
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < SLOT_N; i++)
        if (!live[i])
          return i;
      return -1;
    endfunction

    function void wipe(int s);
      live[s] = 1'b0;
      tab[s] = '0;
    endfunction

    function void note_event(in_item_t it);
      out_item_t  r;
      int         s;
      logic [5:0] pc;
      r = '0;
      s = -1;
      pc = (it.pointer_count > MAX_CONTACTS) ? MAX_CONTACTS : it.pointer_count;
      r.consumed = 1'b1;
      items_seen++;
      case (it.kind)
        KIND_DOWN, KIND_PTR_DOWN: begin
          s = free_slot();
          if (s >= 0) begin
            live[s] = 1'b1;
            tab[s].pointer_id = it.pointer_id;
            tab[s].x = it.x_pos;
            tab[s].y = it.y_pos;
            tab[s].pressure = it.pressure_in;
          end else begin
            full_downs++;
          end
          contacts = (it.kind == KIND_DOWN) ? 6'd1 : pc;
        end
        KIND_MOVE: begin
          s = slot_of(it.pointer_id);
          if (s >= 0) begin
            tab[s].prev_x = tab[s].x;
            tab[s].prev_y = tab[s].y;
            tab[s].x = it.x_pos;
            tab[s].y = it.y_pos;
            tab[s].pressure = it.pressure_in;
          end else begin
            id_misses++;
          end
          contacts = pc;
        end
        KIND_UP, KIND_PTR_UP: begin
          s = slot_of(it.pointer_id);
          if (s >= 0)
            wipe(s);
          else
            id_misses++;
          if (it.kind == KIND_UP)
            contacts = '0;
          else
            contacts = (pc > 0) ? pc - 6'd1 : 6'd0;
        end
        KIND_CANCEL: begin
          for (int i = 0; i < SLOT_N; i++)
            wipe(i);
          contacts = '0;
        end
        KIND_READ: begin
          if (it.query_slot < SLOT_N && live[it.query_slot]) begin
            r.read_valid = 1'b1;
            r.read_pointer_id = tab[it.query_slot].pointer_id;
            r.read_x = tab[it.query_slot].x;
            r.read_y = tab[it.query_slot].y;
            r.read_prev_x = tab[it.query_slot].prev_x;
            r.read_prev_y = tab[it.query_slot].prev_y;
            r.read_pressure = tab[it.query_slot].pressure;
            read_hits++;
          end
        end
        default: r.consumed = 1'b0;
      endcase
      if (s >= 0) begin
        r.slot_found = 1'b1;
        r.slot_index = s[3:0];
      end
      r.active_count = contacts;
      due.push_back(r);
    endfunction

    function void cmp(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      results_seen++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %0h", $time, got);
        return;
      end
      want = due.pop_front();
      cmp("consumed", 16'(want.consumed), 16'(got.consumed));
      cmp("slot_found", 16'(want.slot_found), 16'(got.slot_found));
      cmp("slot_index", 16'(want.slot_index), 16'(got.slot_index));
      cmp("active_count", 16'(want.active_count), 16'(got.active_count));
      cmp("read_valid", 16'(want.read_valid), 16'(got.read_valid));
      cmp("read_pointer_id", 16'(want.read_pointer_id), 16'(got.read_pointer_id));
      cmp("read_x", want.read_x, got.read_x);
      cmp("read_y", want.read_y, got.read_y);
      cmp("read_prev_x", want.read_prev_x, got.read_prev_x);
      cmp("read_prev_y", want.read_prev_y, got.read_prev_y);
      cmp("read_pressure", 16'(want.read_pressure), 16'(got.read_pressure));
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  contact_table book;
  bit           tx_steady;
  bit           rx_steady;
  int           live_ids[$];
  int unsigned  cycles;

  multitouch_slot_tracker_core #(
    .SLOT_COUNT(SLOT_N)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multitouch_slot_tracker_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      book.note_event(in_data);
    if (!rst && out_valid && out_ready)
      book.check_report(out_data);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t ev_of(logic [2:0] k, int id, int x, int y, int pr, int pc,
                                     int qs);
    in_item_t e;
    e.kind = k;
    e.pointer_id = 5'(id);
    e.x_pos = 16'(x);
    e.y_pos = 16'(y);
    e.pressure_in = 8'(pr);
    e.pointer_count = 6'(pc);
    e.query_slot = 4'(qs);
    return e;
  endfunction

  // mostly gesture-shaped traffic: downs, moves and lifts on ids that are in play
  function automatic in_item_t next_event();
    in_item_t e;
    int       r;
    int       k;
    r = $urandom_range(0, 99);
    e = ev_of(KIND_READ, $urandom_range(0, 31), $urandom, $urandom, $urandom_range(0, 255),
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 10),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 9));
    if (r < 22) begin
      e.kind = $urandom_range(0, 1) ? KIND_DOWN : KIND_PTR_DOWN;
      if (live_ids.size() < SLOT_N + 2)
        live_ids.push_back(int'(e.pointer_id));
    end else if (r < 55) begin
      e.kind = KIND_MOVE;
      if (live_ids.size() > 0 && $urandom_range(0, 9) != 0)
        e.pointer_id = 5'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
    end else if (r < 70) begin
      e.kind = $urandom_range(0, 1) ? KIND_UP : KIND_PTR_UP;
      if (live_ids.size() > 0 && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, live_ids.size() - 1);
        e.pointer_id = 5'(live_ids[k]);
        live_ids.delete(k);
      end
    end else if (r < 88) begin
      e.kind = KIND_READ;
    end else if (r < 91) begin
      e.kind = KIND_CANCEL;
      live_ids.delete();
    end else if (r < 95) begin
      e.kind = KIND_OTHER;
    end else begin
      e.kind = 3'($urandom_range(0, 7));
      e.pointer_count = 6'($urandom_range(0, 63));
      e.query_slot = 4'($urandom_range(0, 15));
    end
    return e;
  endfunction

  task automatic send_event(in_item_t e);
    int gap;
    in_valid <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (!in_ready);
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.due.size() != 0);
  endtask

  initial begin
    int run;
    int hold;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      run = $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = rx_steady ? 0 : idle_len();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t plan[$];
    in_item_t e;
    int       handled;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    book = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, ignored kind, extremes of every field
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, 0));
    plan.push_back(ev_of(KIND_OTHER, 31, 'hffff, 'hffff, 255, 63, 15));
    plan.push_back(ev_of(KIND_DOWN, 0, 0, 0, 0, 0, 0));
    plan.push_back(ev_of(KIND_PTR_DOWN, 31, 'hffff, 'hffff, 255, 63, 15));
    // duplicate id, then a move must pick the lowest slot
    plan.push_back(ev_of(KIND_PTR_DOWN, 0, 'h1234, 'h4321, 128, 32, 0));
    plan.push_back(ev_of(KIND_MOVE, 0, 16, 32, 7, 33, 0));
    plan.push_back(ev_of(KIND_MOVE, 17, 5, 5, 5, 5, 0));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, 0));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, 1));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, 15));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, SLOT_N));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, SLOT_N - 1));
    for (int i = 1; i <= SLOT_N - 3; i++)
      plan.push_back(ev_of(KIND_PTR_DOWN, i, i * 100, i * 200, i * 30, i + 2, 0));
    // table full
    plan.push_back(ev_of(KIND_DOWN, 20, 'haaaa, 'h5555, 99, 1, 0));
    plan.push_back(ev_of(KIND_PTR_UP, 0, 0, 0, 0, 0, 0));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, 0));
    plan.push_back(ev_of(KIND_DOWN, 21, 'h0f0f, 'hf0f0, 1, 0, 0));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, 0));
    plan.push_back(ev_of(KIND_UP, 31, 0, 0, 0, 12, 0));
    plan.push_back(ev_of(KIND_PTR_UP, 25, 0, 0, 0, 1, 0));
    plan.push_back(ev_of(KIND_CANCEL, 0, 0, 0, 0, 7, 0));
    plan.push_back(ev_of(KIND_READ, 0, 0, 0, 0, 0, 3));
    foreach (plan[i])
      send_event(plan[i]);
    settle();

    handled = 0;
    while (handled < RANDOM_N) begin
      e = next_event();
      if (e.kind != KIND_OTHER)
        handled++;
      send_event(e);
      if (handled == 150 || handled == 350)
        settle();
      tx_steady = (handled >= 200 && handled < 260);
      rx_steady = (handled >= 220 && handled < 280);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d events checked against %0d results, %0d mismatches",
             book.items_seen, book.results_seen, book.errors);
    $display("%0d reads of live slots, %0d downs on a full table, %0d unmatched moves or lifts",
             book.read_hits, book.full_downs, book.id_misses);
    if (book.errors == 0 && book.due.size() == 0)
      $display("multitouch_slot_tracker_core test passed");
    else
      $display("multitouch_slot_tracker_core test failed");
    $finish;
  end

endmodule
